FILE: sv/mpms_pkg.sv
// ----------------------------------------------------------------------------
// mpms_pkg
// Shared constants, codes and helpers for the Manhattan p-median search.
// ----------------------------------------------------------------------------
package mpms_pkg;

    localparam int MAX_HOUSES = 128;
    localparam int MAX_SITES  = 16;
    localparam int MAX_SIDE   = 64;

    localparam int HIDX_W  = $clog2(MAX_HOUSES);
    localparam int HCNT_W  = $clog2(MAX_HOUSES + 1);
    localparam int SIDX_W  = $clog2(MAX_SITES);
    localparam int SCNT_W  = $clog2(MAX_SITES + 1);
    localparam int MASK_W  = MAX_SITES + 1;
    localparam int COORD_W = 7;
    localparam int DIST_W  = 7;
    localparam int TOTAL_W = 14;
    localparam int SIDE_W  = 7;
    localparam int OPEN_W  = 5;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 1;

    localparam logic [TOTAL_W-1:0] DIST_MAX = '1;
    localparam logic [DIST_W-1:0]  NEAR_INIT = '1;

    // cell content codes
    localparam logic [1:0] KIND_HOUSE = 2'd1;
    localparam logic [1:0] KIND_SITE  = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_GRID_SIDE = 1'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_OPEN  = 1'd1;

    function automatic logic [SCNT_W-1:0] popcount(input logic [MASK_W-1:0] v);
        logic [SCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_SITES; i++)
        begin
            n = n + SCNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: sv/mpms_ifs.sv
// ----------------------------------------------------------------------------
// mpms channel interfaces
// Valid/ready channels for grid cells in and the search result out.
// ----------------------------------------------------------------------------
interface mpms_cell_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_kind;
    logic       last_cell;

    modport source (output valid, output cell_kind, output last_cell, input ready);
    modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

interface mpms_result_if;
    logic                           valid;
    logic                           ready;
    logic [mpms_pkg::TOTAL_W-1:0]   total_distance;
    logic                           no_site;

    modport source (output valid, output total_distance, output no_site, input ready);
    modport sink   (input valid, input total_distance, input no_site, output ready);
endinterface

FILE: sv/manhattan_p_median_search.sv
// ----------------------------------------------------------------------------
// manhattan_p_median_search
// Loads a grid of cells, then finds the least total house-to-nearest-site
// Manhattan distance over all choices of open sites.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle in row-major order. After the cell marked
// last, the block stops taking cells and runs the search with a single
// distance/compare unit: it walks every site mask, and for each mask with
// min(max_open, sites) members it reads each house from memory, steps
// through every stored site to find the nearest open one, and then folds
// the sum into the running best. The result is then handed to an output
// register and cell loading resumes while it waits to be taken. A grid
// without sites skips the search and answers with no_site set.
// ----------------------------------------------------------------------------
module manhattan_p_median_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mpms_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [mpms_pkg::CFG_W-1:0]       cfg_data,
    mpms_cell_if.sink                        cell_in,
    mpms_result_if.source                    result_out
);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_MASK  = 7'b0000100,
        ST_HWAIT = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_MEND  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [mpms_pkg::SIDE_W-1:0]  grid_side_reg;
    logic [mpms_pkg::OPEN_W-1:0]  max_open_reg;

    logic [mpms_pkg::COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic [mpms_pkg::COORD_W-1:0] cursor_col_reg, cursor_col_next;
    logic [mpms_pkg::HCNT_W-1:0]  house_count_reg, house_count_next;
    logic [mpms_pkg::SCNT_W-1:0]  site_count_reg, site_count_next;

    logic [mpms_pkg::COORD_W-1:0] site_row_reg [mpms_pkg::MAX_SITES];
    logic [mpms_pkg::COORD_W-1:0] site_col_reg [mpms_pkg::MAX_SITES];

    logic [mpms_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [mpms_pkg::SCNT_W-1:0]  k_reg, k_next;
    logic [mpms_pkg::HCNT_W-1:0]  h_reg, h_next;
    logic [mpms_pkg::SIDX_W-1:0]  s_reg, s_next;
    logic [mpms_pkg::DIST_W-1:0]  near_reg, near_next;
    logic [mpms_pkg::TOTAL_W-1:0] sum_reg, sum_next;
    logic [mpms_pkg::TOTAL_W-1:0] best_reg, best_next;
    logic                         nosite_reg, nosite_next;

    logic                         out_valid_reg, out_valid_next;
    logic [mpms_pkg::TOTAL_W-1:0] out_total_reg, out_total_next;
    logic                         out_nosite_reg, out_nosite_next;

    logic [mpms_pkg::SIDE_W-1:0]  side;
    logic                         accept;
    logic                         in_grid;
    logic                         store_house;
    logic                         store_site;
    logic                         out_free;

    logic [2*mpms_pkg::COORD_W-1:0] ram_wr_data;
    logic [2*mpms_pkg::COORD_W-1:0] ram_rd_data;
    logic [mpms_pkg::COORD_W-1:0]   h_row, h_col;

    logic [mpms_pkg::DIST_W:0]    site_dist;
    logic [mpms_pkg::DIST_W-1:0]  near_cand;
    logic [mpms_pkg::TOTAL_W:0]   sum_add;
    logic [mpms_pkg::TOTAL_W-1:0] sum_sat;
    logic [mpms_pkg::SCNT_W-1:0]  open_lim;
    logic [mpms_pkg::MASK_W-1:0]  mask_limit;
    logic                         last_site;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= mpms_pkg::SIDE_W'(5);
            max_open_reg  <= mpms_pkg::OPEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mpms_pkg::REG_GRID_SIDE: grid_side_reg <= cfg_data;
                mpms_pkg::REG_MAX_OPEN:  max_open_reg  <= cfg_data[mpms_pkg::OPEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_side_reg == '0)
            side = mpms_pkg::SIDE_W'(1);
        else if (grid_side_reg > mpms_pkg::SIDE_W'(mpms_pkg::MAX_SIDE))
            side = mpms_pkg::SIDE_W'(mpms_pkg::MAX_SIDE);
        else
            side = grid_side_reg;
    end

    // ---------------- cell loading ----------------
    assign cell_in.ready = (state_reg == ST_LOAD);
    assign accept        = cell_in.valid && cell_in.ready;
    assign in_grid       = (cursor_row_reg <= side);
    assign store_house   = accept && in_grid && (cell_in.cell_kind == mpms_pkg::KIND_HOUSE)
                           && (house_count_reg < mpms_pkg::HCNT_W'(mpms_pkg::MAX_HOUSES));
    assign store_site    = accept && in_grid && (cell_in.cell_kind == mpms_pkg::KIND_SITE)
                           && (site_count_reg < mpms_pkg::SCNT_W'(mpms_pkg::MAX_SITES));
    assign ram_wr_data   = {cursor_row_reg, cursor_col_reg};

    mpms_ram #(
        .WIDTH (2 * mpms_pkg::COORD_W),
        .DEPTH (mpms_pkg::MAX_HOUSES)
    ) u_house_ram (
        .clk     (clk),
        .we      (store_house),
        .wr_addr (house_count_reg[mpms_pkg::HIDX_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_addr (h_reg[mpms_pkg::HIDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign h_row = ram_rd_data[2*mpms_pkg::COORD_W-1:mpms_pkg::COORD_W];
    assign h_col = ram_rd_data[mpms_pkg::COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (store_site)
        begin
            site_row_reg[site_count_reg[mpms_pkg::SIDX_W-1:0]] <= cursor_row_reg;
            site_col_reg[site_count_reg[mpms_pkg::SIDX_W-1:0]] <= cursor_col_reg;
        end
    end

    // ---------------- shared distance unit ----------------
    assign site_dist = {1'b0, mpms_pkg::absdiff(h_row, site_row_reg[s_reg])}
                     + {1'b0, mpms_pkg::absdiff(h_col, site_col_reg[s_reg])};
    assign near_cand = (mask_reg[s_reg] && (site_dist < {1'b0, near_reg}))
                       ? site_dist[mpms_pkg::DIST_W-1:0] : near_reg;
    assign sum_add   = {1'b0, sum_reg}
                     + {{(mpms_pkg::TOTAL_W + 1 - mpms_pkg::DIST_W){1'b0}}, near_cand};
    assign sum_sat   = (sum_add > {1'b0, mpms_pkg::DIST_MAX})
                       ? mpms_pkg::DIST_MAX : sum_add[mpms_pkg::TOTAL_W-1:0];
    assign last_site = ({1'b0, s_reg} == (site_count_reg - mpms_pkg::SCNT_W'(1)));

    assign open_lim   = (max_open_reg == '0) ? mpms_pkg::SCNT_W'(1) : max_open_reg;
    assign mask_limit = mpms_pkg::MASK_W'(1) << site_count_reg;
    assign out_free   = !out_valid_reg || result_out.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        cursor_row_next  = cursor_row_reg;
        cursor_col_next  = cursor_col_reg;
        house_count_next = house_count_reg;
        site_count_next  = site_count_reg;
        mask_next        = mask_reg;
        k_next           = k_reg;
        h_next           = h_reg;
        s_next           = s_reg;
        near_next        = near_reg;
        sum_next         = sum_reg;
        best_next        = best_reg;
        nosite_next      = nosite_reg;
        out_valid_next   = out_valid_reg;
        out_total_next   = out_total_reg;
        out_nosite_next  = out_nosite_reg;

        if (out_valid_reg && result_out.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_house)
                        house_count_next = house_count_reg + mpms_pkg::HCNT_W'(1);
                    if (store_site)
                        site_count_next = site_count_reg + mpms_pkg::SCNT_W'(1);
                    if (in_grid)
                    begin
                        if (cursor_col_reg >= side)
                        begin
                            cursor_col_next = mpms_pkg::COORD_W'(1);
                            cursor_row_next = cursor_row_reg + mpms_pkg::COORD_W'(1);
                        end
                        else
                        begin
                            cursor_col_next = cursor_col_reg + mpms_pkg::COORD_W'(1);
                        end
                    end
                    if (cell_in.last_cell)
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                best_next = mpms_pkg::DIST_MAX;
                mask_next = mpms_pkg::MASK_W'(1);
                k_next    = (open_lim > site_count_reg) ? site_count_reg : open_lim;
                if (site_count_reg == '0)
                begin
                    nosite_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    nosite_next = 1'b0;
                    state_next  = ST_MASK;
                end
            end
            ST_MASK:
            begin
                if (mask_reg == mask_limit)
                    state_next = ST_FIN;
                else if (mpms_pkg::popcount(mask_reg) == k_reg)
                begin
                    h_next   = '0;
                    sum_next = '0;
                    state_next = (house_count_reg == '0) ? ST_MEND : ST_HWAIT;
                end
                else
                    mask_next = mask_reg + mpms_pkg::MASK_W'(1);
            end
            ST_HWAIT:
            begin
                // house coordinates arrive from the memory next cycle
                s_next     = '0;
                near_next  = mpms_pkg::NEAR_INIT;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                near_next = near_cand;
                s_next    = s_reg + mpms_pkg::SIDX_W'(1);
                if (last_site)
                begin
                    sum_next = sum_sat;
                    h_next   = h_reg + mpms_pkg::HCNT_W'(1);
                    if ((h_reg + mpms_pkg::HCNT_W'(1)) == house_count_reg)
                        state_next = ST_MEND;
                    else
                        state_next = ST_HWAIT;
                end
            end
            ST_MEND:
            begin
                if (sum_reg < best_reg)
                    best_next = sum_reg;
                mask_next  = mask_reg + mpms_pkg::MASK_W'(1);
                state_next = ST_MASK;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_total_next   = best_reg;
                    out_nosite_next  = nosite_reg;
                    house_count_next = '0;
                    site_count_next  = '0;
                    cursor_row_next  = mpms_pkg::COORD_W'(1);
                    cursor_col_next  = mpms_pkg::COORD_W'(1);
                    best_next        = mpms_pkg::DIST_MAX;
                    state_next       = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            cursor_row_reg  <= mpms_pkg::COORD_W'(1);
            cursor_col_reg  <= mpms_pkg::COORD_W'(1);
            house_count_reg <= '0;
            site_count_reg  <= '0;
            best_reg        <= mpms_pkg::DIST_MAX;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_row_reg  <= cursor_row_next;
            cursor_col_reg  <= cursor_col_next;
            house_count_reg <= house_count_next;
            site_count_reg  <= site_count_next;
            best_reg        <= best_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        k_reg          <= k_next;
        h_reg          <= h_next;
        s_reg          <= s_next;
        near_reg       <= near_next;
        sum_reg        <= sum_next;
        nosite_reg     <= nosite_next;
        out_total_reg  <= out_total_next;
        out_nosite_reg <= out_nosite_next;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.total_distance = out_total_reg;
    assign result_out.no_site        = out_nosite_reg;

endmodule

FILE: sv/mpms_ram.sv
// ----------------------------------------------------------------------------
// mpms_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for manhattan_p_median_search. Grids of cells are
// pushed through the cell channel with random gaps. The result channel is
// stalled at random. A scoreboard replays every accepted cell, searches the
// site subsets itself and compares each answer with the oldest one pending.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [mpms_pkg::TOTAL_W-1:0] total_distance;
    logic                         no_site;
} grid_answer_t;

class grid_search_scoreboard;
    bit [6:0]     side_reg;
    bit [4:0]     open_reg;
    bit [6:0]     house_row [mpms_pkg::MAX_HOUSES];
    bit [6:0]     house_col [mpms_pkg::MAX_HOUSES];
    int unsigned  house_count;
    bit [6:0]     site_row [mpms_pkg::MAX_SITES];
    bit [6:0]     site_col [mpms_pkg::MAX_SITES];
    int unsigned  site_count;
    int unsigned  cur_row;
    int unsigned  cur_col;
    grid_answer_t expected_answers[$];
    int unsigned  mismatches;
    int unsigned  grids_seen;
    int unsigned  siteless_grids;
    int unsigned  peak_sites;
    int unsigned  peak_houses;

    function new();
        side_reg       = 7'd5;
        open_reg       = 5'd1;
        mismatches     = 0;
        grids_seen     = 0;
        siteless_grids = 0;
        peak_sites     = 0;
        peak_houses    = 0;
        clear_grid();
    endfunction

    function void clear_grid();
        house_count = 0;
        site_count  = 0;
        cur_row     = 1;
        cur_col     = 1;
    endfunction

    function void set_reg(logic [mpms_pkg::CIDX_W-1:0] index, bit [6:0] value);
        if (index == mpms_pkg::REG_GRID_SIDE)
            side_reg = value;
        else
            open_reg = value[4:0];
    endfunction

    function int unsigned outstanding();
        return expected_answers.size();
    endfunction

    // Only subsets of exactly min(max_open, sites) members can hold the minimum.
    function int unsigned least_total();
        int unsigned k;
        int unsigned best;
        int unsigned sum;
        int unsigned near;
        int unsigned d;
        int unsigned mask;
        k = (open_reg == 0) ? 1 : open_reg;
        if (k > site_count)
            k = site_count;
        best = mpms_pkg::DIST_MAX;
        for (mask = 1; mask < (1 << site_count); mask++)
        begin
            if ($countones(mask) != k)
                continue;
            sum = 0;
            for (int h = 0; h < house_count; h++)
            begin
                near = 127;
                for (int s = 0; s < site_count; s++)
                begin
                    if (mask[s])
                    begin
                        d = ((house_row[h] > site_row[s]) ? house_row[h] - site_row[s]
                                                          : site_row[s] - house_row[h])
                          + ((house_col[h] > site_col[s]) ? house_col[h] - site_col[s]
                                                          : site_col[s] - house_col[h]);
                        if (d < near)
                            near = d;
                    end
                end
                sum = sum + near;
                if (sum > mpms_pkg::DIST_MAX)
                    sum = mpms_pkg::DIST_MAX;
            end
            if (sum < best)
                best = sum;
        end
        return best;
    endfunction

    function void take_cell(logic [1:0] kind, logic last);
        int unsigned  side;
        grid_answer_t ans;
        side = (side_reg == 0) ? 1 : (side_reg > mpms_pkg::MAX_SIDE) ? mpms_pkg::MAX_SIDE
                                                                      : side_reg;
        // past the last row the cursor parks and nothing is stored
        if (cur_row <= side)
        begin
            if (kind == mpms_pkg::KIND_HOUSE && house_count < mpms_pkg::MAX_HOUSES)
            begin
                house_row[house_count] = 7'(cur_row);
                house_col[house_count] = 7'(cur_col);
                house_count++;
            end
            else if (kind == mpms_pkg::KIND_SITE && site_count < mpms_pkg::MAX_SITES)
            begin
                site_row[site_count] = 7'(cur_row);
                site_col[site_count] = 7'(cur_col);
                site_count++;
            end
            if (cur_col >= side)
            begin
                cur_col = 1;
                cur_row++;
            end
            else
                cur_col++;
        end
        if (last)
        begin
            grids_seen++;
            if (site_count > peak_sites)
                peak_sites = site_count;
            if (house_count > peak_houses)
                peak_houses = house_count;
            if (site_count == 0)
            begin
                ans.total_distance = mpms_pkg::DIST_MAX;
                ans.no_site        = 1'b1;
                siteless_grids++;
            end
            else
            begin
                ans.total_distance = mpms_pkg::TOTAL_W'(least_total());
                ans.no_site        = 1'b0;
            end
            expected_answers = {expected_answers, ans};
            clear_grid();
        end
    endfunction

    function void check_answer(logic [mpms_pkg::TOTAL_W-1:0] total, logic no_site);
        grid_answer_t want;
        if (expected_answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] answer with none pending: total_distance=%0d no_site=%0b",
                         $time, total, no_site);
            return;
        end
        want = expected_answers.pop_front();
        if (want.total_distance !== total || want.no_site !== no_site)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"[%0t] answer mismatch: expected total_distance=%0d no_site=%0b,",
                          " got total_distance=%0d no_site=%0b"},
                         $time, want.total_distance, want.no_site, total, no_site);
        end
    endfunction

    function int unsigned close_out();
        if (expected_answers.size() != 0)
        begin
            $display("%0d answers never arrived", expected_answers.size());
            mismatches += expected_answers.size();
        end
        return mismatches;
    endfunction
endclass

module tb_top;

    localparam logic [1:0] KIND_EMPTY   = 2'd0;
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    // slowest grids are those with 16 stored sites; the rest are small
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         RANDOM_CELLS = 1200;
    localparam int         PHASE_CELLS  = 100;
    localparam int         SETTLE       = 8;
    localparam int         TAIL_CYCLES  = 100;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [mpms_pkg::CIDX_W-1:0] cfg_index;
    logic [mpms_pkg::CFG_W-1:0]  cfg_data;

    mpms_cell_if   cell_bus ();
    mpms_result_if result_bus ();

    grid_search_scoreboard sb = new();

    bit          steady = 1'b0;
    int unsigned cycles = 0;
    int unsigned random_cells = 0;
    int unsigned settings_used = 0;
    int unsigned phase_sides [10] = '{2, 3, 4, 5, 6, 8, 0, 1, 64, 127};
    int unsigned phase_opens [10] = '{1, 2, 3, 31, 0, 4, 2, 16, 5, 3};

    manhattan_p_median_search u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_in    (cell_bus),
        .result_out (result_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cell_bus.valid && cell_bus.ready)
                sb.take_cell(cell_bus.cell_kind, cell_bus.last_cell);
            if (result_bus.valid && result_bus.ready)
                sb.check_answer(result_bus.total_distance, result_bus.no_site);
        end
    end

    // result side back-pressure: mostly ready, short stalls, a few long ones
    initial
    begin : result_stall
        int unsigned hold;
        int unsigned r;
        bit          lvl;
        hold = 0;
        lvl  = 1'b0;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady)
                result_bus.ready <= 1'b1;
            else
            begin
                if (hold == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                    begin
                        lvl  = 1'b1;
                        hold = $urandom_range(1, 20);
                    end
                    else if (r < 95)
                    begin
                        lvl  = 1'b0;
                        hold = $urandom_range(1, 4);
                    end
                    else
                    begin
                        lvl  = 1'b0;
                        hold = $urandom_range(20, 200);
                    end
                end
                result_bus.ready <= lvl;
                hold--;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_side(input int unsigned raw);
        if (raw == 0)
            return 1;
        else if (raw > mpms_pkg::MAX_SIDE)
            return mpms_pkg::MAX_SIDE;
        else
            return raw;
    endfunction

    // entered and left at a falling edge
    task automatic send_cell(input logic [1:0] kind, input logic last);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            cell_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_bus.valid     <= 1'b1;
        cell_bus.cell_kind <= kind;
        cell_bus.last_cell <= last;
        do
        begin
            @(posedge clk);
        end
        while (!cell_bus.ready);
        @(negedge clk);
    endtask

    // sender holds off until every pending answer has been taken
    task automatic drain();
        cell_bus.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.outstanding() != 0);
    endtask

    task automatic reconfigure(input logic [6:0] side_val, input logic [4:0] open_val);
        drain();
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= mpms_pkg::REG_GRID_SIDE;
        cfg_data  <= side_val;
        @(negedge clk);
        cfg_index <= mpms_pkg::REG_MAX_OPEN;
        cfg_data  <= mpms_pkg::CFG_W'(open_val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        sb.set_reg(mpms_pkg::REG_GRID_SIDE, side_val);
        sb.set_reg(mpms_pkg::REG_MAX_OPEN, 7'(open_val));
        settings_used++;
    endtask

    // cells past the grid area get any kind, including the unused code
    task automatic send_grid(input int unsigned side, input int unsigned ncells,
                             input int unsigned site_budget, input int unsigned house_pct,
                             input int unsigned site_pct);
        int unsigned area;
        int unsigned placed;
        int unsigned r;
        logic [1:0]  kind;
        area   = side * side;
        placed = 0;
        for (int unsigned i = 0; i < ncells; i++)
        begin
            r = $urandom_range(0, 99);
            if (i >= area)
                kind = 2'($urandom_range(0, 3));
            else if (r < house_pct)
                kind = mpms_pkg::KIND_HOUSE;
            else if (r < house_pct + site_pct && placed < site_budget)
            begin
                kind = mpms_pkg::KIND_SITE;
                placed++;
            end
            else if (r >= 96)
                kind = KIND_SPARE;
            else
                kind = KIND_EMPTY;
            send_cell(kind, i == ncells - 1);
        end
        random_cells += ncells;
    endtask

    // few sites per grid keep the subset search short
    task automatic random_grid(input int unsigned side);
        int unsigned area;
        int unsigned n;
        int unsigned r;
        area = side * side;
        r    = $urandom_range(0, 99);
        if (side > 8)
            n = $urandom_range(1, 140);
        else if (r < 70)
            n = area;
        else if (r < 85)
            n = $urandom_range(1, area);
        else
            n = area + $urandom_range(1, 6);
        send_grid(side, n, $urandom_range(0, 5), $urandom_range(10, 45),
                  $urandom_range(5, 30));
    endtask

    task automatic run_phase(input logic [6:0] side_val, input logic [4:0] open_val);
        int unsigned phase_end;
        reconfigure(side_val, open_val);
        steady    = ($urandom_range(0, 3) == 0);
        phase_end = random_cells + PHASE_CELLS;
        while (random_cells < phase_end)
        begin
            random_grid(eff_side(side_val));
            if ($urandom_range(0, 5) == 0)
                drain();
        end
        steady = 1'b0;
    endtask

    initial
    begin : main
        int unsigned failures;
        int unsigned p;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        cell_bus.valid     = 1'b0;
        cell_bus.cell_kind = KIND_EMPTY;
        cell_bus.last_cell = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: side 5, one site open; grid cut short by last_cell
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(mpms_pkg::KIND_SITE, 1'b0);
        send_cell(KIND_EMPTY, 1'b0);
        send_cell(KIND_SPARE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b1);
        // one-cell grid: the house lands past the last row
        reconfigure(7'd1, 5'd0);
        send_cell(mpms_pkg::KIND_SITE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b1);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b1);
        // max_open above the site count opens every site
        reconfigure(7'd2, 5'd31);
        send_cell(mpms_pkg::KIND_SITE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(mpms_pkg::KIND_SITE, 1'b1);
        // side 0 acts as 1: site without houses, then unused code alone
        reconfigure(7'd0, 5'd1);
        send_cell(mpms_pkg::KIND_SITE, 1'b1);
        send_cell(KIND_SPARE, 1'b1);
        // side above the maximum clamps to 64
        reconfigure(7'd127, 5'd2);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(KIND_EMPTY, 1'b0);
        send_cell(mpms_pkg::KIND_SITE, 1'b0);
        send_cell(KIND_SPARE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(mpms_pkg::KIND_SITE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b0);
        send_cell(mpms_pkg::KIND_HOUSE, 1'b1);

        // site overflow with all sites open, then with one open
        reconfigure(7'd5, 5'd31);
        send_grid(5, 25, 25, 12, 88);
        reconfigure(7'd5, 5'd1);
        send_grid(5, 25, 25, 12, 88);
        // house overflow
        reconfigure(7'd12, 5'd2);
        send_grid(12, 144, 2, 95, 5);

        p = 0;
        while (random_cells < RANDOM_CELLS)
        begin
            if (p < 10)
                run_phase(7'(phase_sides[p]), 5'(phase_opens[p]));
            else if ($urandom_range(0, 9) < 7)
                run_phase(7'($urandom_range(2, 8)), 5'($urandom_range(0, 31)));
            else
                run_phase(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
            p++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        failures = sb.close_out();
        $display("Covered %0d grids (%0d without a site) over %0d register settings,",
                 sb.grids_seen, sb.siteless_grids, settings_used + 1);
        $display("up to %0d sites and %0d houses stored; %0d failures",
                 sb.peak_sites, sb.peak_houses, failures);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/mpms_pkg.sv
sv/mpms_ifs.sv
sv/mpms_ram.sv
sv/manhattan_p_median_search.sv
tb/sv/tb_top.sv
